[src/crct_pkg.sv]
// Shared types, constants and register codes of the Catmull-Rom curve tessellator.
`default_nettype none
package crct_pkg;

   localparam int COORD_BITS  = 32;
   localparam int T_FRAC_BITS = 16;
   localparam int SCALE_BITS  = 32;
   localparam int SCALE_FRAC  = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Smallest step: one sixty-fourth of the unit interval, so a run has at most 64 samples.
   localparam logic [T_FRAC_BITS-1:0] T_MIN_STEP = T_FRAC_BITS'(1 << (T_FRAC_BITS - 6));
   localparam logic [T_FRAC_BITS-1:0] T_HALF     = T_FRAC_BITS'(1 << (T_FRAC_BITS - 1));

   // Datapath widths of the sample evaluator.
   localparam int W_BITS    = T_FRAC_BITS + 4;
   localparam int PROD_BITS = W_BITS + COORD_BITS;
   localparam int SUM_BITS  = PROD_BITS + 2;
   localparam int MID_BITS  = SUM_BITS - (T_FRAC_BITS + 1);
   localparam int SPLIT     = 18;
   localparam int HI_BITS   = MID_BITS - SPLIT;
   localparam int PART_BITS = HI_BITS + SCALE_BITS;
   localparam int TOT_BITS  = MID_BITS + SCALE_BITS + 1;
   localparam int RES_BITS  = TOT_BITS - SCALE_FRAC;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      REG_T_STEP  = 2'd0,
      REG_SCALE_X = 2'd1,
      REG_SCALE_Y = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         start_curve;
   } point_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] sample_x;
      logic signed [COORD_BITS-1:0] sample_y;
      logic                         last_sample;
   } sample_type;

   // Four control points of one segment, index 0 the oldest.
   typedef struct packed {
      logic [3:0][COORD_BITS-1:0] px;
      logic [3:0][COORD_BITS-1:0] py;
   } window_type;

   typedef struct packed {
      logic [T_FRAC_BITS-1:0]       t_step;
      logic signed [SCALE_BITS-1:0] scale_x;
      logic signed [SCALE_BITS-1:0] scale_y;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      EV_IDLE,
      EV_SQUARE,
      EV_CUBE,
      EV_WEIGHT,
      EV_MUL,
      EV_SUM,
      EV_SCALE,
      EV_ROUND
   } eval_state_type;

endpackage
`default_nettype wire

[src/crct_front.sv]
// Front end: takes control points, keeps the window and hands complete segments to the queue.
`default_nettype none
module crct_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  crct_pkg::point_type         req_data,
   input  crct_pkg::queue_status_type  q_status,
   output logic                        push,
   output crct_pkg::window_type        push_win
);

   logic [2:0][crct_pkg::COORD_BITS-1:0] win_x_ff, win_x_in;
   logic [2:0][crct_pkg::COORD_BITS-1:0] win_y_ff, win_y_in;
   logic [1:0]                           held_ff, held_in;
   logic [1:0]                           held_eff;
   logic                                 accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      held_eff = req_data.start_curve ? 2'd0 : held_ff;
      held_in  = held_ff;
      win_x_in = win_x_ff;
      win_y_in = win_y_ff;
      push     = 1'b0;
      push_win.px = {req_data.point_x, win_x_ff[2], win_x_ff[1], win_x_ff[0]};
      push_win.py = {req_data.point_y, win_y_ff[2], win_y_ff[1], win_y_ff[0]};
      if (accept) begin
         if (held_eff != 2'd3) begin
            // Still filling: store the point, nothing to evaluate yet.
            win_x_in[held_eff] = req_data.point_x;
            win_y_in[held_eff] = req_data.point_y;
            held_in = held_eff + 2'd1;
         end else begin
            push = 1'b1;
            win_x_in = {req_data.point_x, win_x_ff[2], win_x_ff[1]};
            win_y_in = {req_data.point_y, win_y_ff[2], win_y_ff[1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      win_x_ff <= win_x_in;
      win_y_ff <= win_y_in;
   end

endmodule
`default_nettype wire

[src/crct_queue.sv]
// Short segment queue between the front end and the evaluator.
`default_nettype none
module crct_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  crct_pkg::window_type        push_win,
   input  wire logic                   pop,
   output crct_pkg::window_type        head_win,
   output crct_pkg::queue_status_type  status
);

   crct_pkg::window_type                    entries_ff [crct_pkg::QUEUE_DEPTH];
   logic [crct_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [crct_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [crct_pkg::QUEUE_CNT_BITS-1:0]     count_ff, count_in;

   assign head_win     = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == crct_pkg::QUEUE_CNT_BITS'(crct_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_win;
      end
   end

endmodule
`default_nettype wire

[src/crct_eval.sv]
// Back end: steps t over one segment and computes each scaled, saturated sample.
`default_nettype none
module crct_eval (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  crct_pkg::cfg_type           cfg,
   input  crct_pkg::window_type        head_win,
   input  crct_pkg::queue_status_type  q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output crct_pkg::sample_type        rsp_data
);

   localparam int TF = crct_pkg::T_FRAC_BITS;
   localparam int WB = crct_pkg::W_BITS;

   crct_pkg::eval_state_type state_ff, state_in;

   logic [TF-1:0] t_ff, step_ff, t2_ff, t3_ff;
   logic [TF:0]   t_next;
   logic [2*TF:0] sq_full, cube_full;
   logic          last;
   logic          load_out;

   logic signed [WB-1:0] te, t2e, t3e;
   logic signed [WB-1:0] w_ff [4];
   logic signed [WB-1:0] w_in [4];
   logic signed [crct_pkg::PROD_BITS-1:0] prod_x_ff [4];
   logic signed [crct_pkg::PROD_BITS-1:0] prod_y_ff [4];
   logic signed [crct_pkg::SUM_BITS-1:0]  acc_x, acc_y;
   logic signed [crct_pkg::MID_BITS-1:0]  mid_x_ff, mid_y_ff;
   logic signed [crct_pkg::PART_BITS-1:0] phi_x_ff, plo_x_ff, phi_y_ff, plo_y_ff;

   logic                     out_valid_ff, out_valid_in;
   crct_pkg::sample_type     out_ff;

   // Recombines the split scale products, rounds half up and saturates to the coordinate width.
   function automatic logic [crct_pkg::COORD_BITS-1:0] round_sat(
      input logic signed [crct_pkg::PART_BITS-1:0] phi,
      input logic signed [crct_pkg::PART_BITS-1:0] plo
   );
      logic signed [crct_pkg::TOT_BITS-1:0] tot;
      logic [crct_pkg::RES_BITS-1:0]        res;
      logic [crct_pkg::RES_BITS-crct_pkg::COORD_BITS:0] top_bits;
      tot = (crct_pkg::TOT_BITS'(phi) <<< crct_pkg::SPLIT) + crct_pkg::TOT_BITS'(plo)
            + crct_pkg::TOT_BITS'(1 << (crct_pkg::SCALE_FRAC - 1));
      res = tot[crct_pkg::TOT_BITS-1:crct_pkg::SCALE_FRAC];
      top_bits = res[crct_pkg::RES_BITS-1:crct_pkg::COORD_BITS-1];
      if ((&top_bits) || !(|top_bits)) begin
         return res[crct_pkg::COORD_BITS-1:0];
      end else if (res[crct_pkg::RES_BITS-1]) begin
         return {1'b1, {(crct_pkg::COORD_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(crct_pkg::COORD_BITS-1){1'b1}}};
      end
   endfunction

   assign t_next = {1'b0, t_ff} + {1'b0, step_ff};
   assign last   = t_next[TF];

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         crct_pkg::EV_IDLE: begin
            if (!q_status.empty) begin
               state_in = crct_pkg::EV_SQUARE;
            end
         end
         crct_pkg::EV_SQUARE: state_in = crct_pkg::EV_CUBE;
         crct_pkg::EV_CUBE:   state_in = crct_pkg::EV_WEIGHT;
         crct_pkg::EV_WEIGHT: state_in = crct_pkg::EV_MUL;
         crct_pkg::EV_MUL:    state_in = crct_pkg::EV_SUM;
         crct_pkg::EV_SUM:    state_in = crct_pkg::EV_SCALE;
         crct_pkg::EV_SCALE:  state_in = crct_pkg::EV_ROUND;
         crct_pkg::EV_ROUND: begin
            // Wait until the output register is free or is being drained.
            if (!out_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               if (last) begin
                  pop      = 1'b1;
                  state_in = crct_pkg::EV_IDLE;
               end else begin
                  state_in = crct_pkg::EV_SQUARE;
               end
            end
         end
         default: state_in = crct_pkg::EV_IDLE;
      endcase
   end

   always_comb begin
      sq_full   = {1'b0, (2*TF)'(t_ff) * (2*TF)'(t_ff)} + (2*TF+1)'(crct_pkg::T_HALF);
      cube_full = {1'b0, (2*TF)'(t2_ff) * (2*TF)'(t_ff)} + (2*TF+1)'(crct_pkg::T_HALF);
      te  = signed'(WB'(t_ff));
      t2e = signed'(WB'(t2_ff));
      t3e = signed'(WB'(t3_ff));
      w_in[0] = (t2e <<< 1) - t3e - te;
      w_in[1] = (t3e <<< 1) + t3e - (t2e <<< 2) - t2e + signed'(WB'(1 << (TF + 1)));
      w_in[2] = (t2e <<< 2) + te - (t3e <<< 1) - t3e;
      w_in[3] = t3e - t2e;
      acc_x = crct_pkg::SUM_BITS'(signed'(1 << TF));
      acc_y = crct_pkg::SUM_BITS'(signed'(1 << TF));
      for (int i = 0; i < 4; i++) begin
         acc_x = acc_x + crct_pkg::SUM_BITS'(prod_x_ff[i]);
         acc_y = acc_y + crct_pkg::SUM_BITS'(prod_y_ff[i]);
      end
      out_valid_in = load_out || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crct_pkg::EV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == crct_pkg::EV_IDLE) begin
         t_ff    <= '0;
         step_ff <= (cfg.t_step < crct_pkg::T_MIN_STEP) ? crct_pkg::T_MIN_STEP : cfg.t_step;
      end else if (load_out && !last) begin
         t_ff <= t_next[TF-1:0];
      end
      if (state_ff == crct_pkg::EV_SQUARE) begin
         t2_ff <= sq_full[2*TF-1:TF];
      end
      if (state_ff == crct_pkg::EV_CUBE) begin
         t3_ff <= cube_full[2*TF-1:TF];
      end
      if (state_ff == crct_pkg::EV_WEIGHT) begin
         for (int i = 0; i < 4; i++) begin
            w_ff[i] <= w_in[i];
         end
      end
      if (state_ff == crct_pkg::EV_MUL) begin
         for (int i = 0; i < 4; i++) begin
            prod_x_ff[i] <= crct_pkg::PROD_BITS'(w_ff[i])
                            * crct_pkg::PROD_BITS'($signed(head_win.px[i]));
            prod_y_ff[i] <= crct_pkg::PROD_BITS'(w_ff[i])
                            * crct_pkg::PROD_BITS'($signed(head_win.py[i]));
         end
      end
      if (state_ff == crct_pkg::EV_SUM) begin
         // Divide the weighted sum by twice the unit with rounding.
         mid_x_ff <= acc_x[crct_pkg::SUM_BITS-1:TF+1];
         mid_y_ff <= acc_y[crct_pkg::SUM_BITS-1:TF+1];
      end
      if (state_ff == crct_pkg::EV_SCALE) begin
         // The wide sample times the scale is cut into a signed high and an unsigned low half.
         phi_x_ff <= crct_pkg::PART_BITS'($signed(mid_x_ff[crct_pkg::MID_BITS-1:crct_pkg::SPLIT]))
                     * crct_pkg::PART_BITS'(cfg.scale_x);
         plo_x_ff <= crct_pkg::PART_BITS'($signed({1'b0, mid_x_ff[crct_pkg::SPLIT-1:0]}))
                     * crct_pkg::PART_BITS'(cfg.scale_x);
         phi_y_ff <= crct_pkg::PART_BITS'($signed(mid_y_ff[crct_pkg::MID_BITS-1:crct_pkg::SPLIT]))
                     * crct_pkg::PART_BITS'(cfg.scale_y);
         plo_y_ff <= crct_pkg::PART_BITS'($signed({1'b0, mid_y_ff[crct_pkg::SPLIT-1:0]}))
                     * crct_pkg::PART_BITS'(cfg.scale_y);
      end
      if (load_out) begin
         out_ff.sample_x    <= round_sat(phi_x_ff, plo_x_ff);
         out_ff.sample_y    <= round_sat(phi_y_ff, plo_y_ff);
         out_ff.last_sample <= last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

[src/catmull_rom_curve_tessellator.sv]
// Top level of the Catmull-Rom curve tessellator: register port, front end, queue and evaluator.
`default_nettype none
// Control points enter on the req channel; the first three of a curve (or after start_curve)
// only fill the window, and every later point closes a segment that the evaluator samples at
// t = 0, step, 2*step ... below one, emitting one scaled, saturated sample per rsp transfer,
// with last_sample set on the final one. The evaluator is a sequencer that takes each sample
// through the states square, cube, weight, multiply, sum, scale and round, and holds in round
// while the result side stalls; a segment has at most 64 samples. The front end keeps taking
// points while the evaluator works, until its two-entry segment queue is full. Registers t_step,
// scale_x and scale_y sit at byte addresses 0, 4 and 8; the user must write them only while the
// block is idle, and the block itself does not enforce this.
module catmull_rom_curve_tessellator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  crct_pkg::point_type                       req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output crct_pkg::sample_type                      rsp_data,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [crct_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [crct_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [crct_pkg::CSR_DATA_BITS-1:0]        prdata,
   output logic                                      pready
);

   logic [crct_pkg::T_FRAC_BITS-1:0]       t_step_ff;
   logic signed [crct_pkg::SCALE_BITS-1:0] scale_x_ff, scale_y_ff;
   crct_pkg::reg_index_type                reg_index;
   logic                                   csr_write;
   crct_pkg::cfg_type                      cfg;

   logic                       q_push, q_pop;
   crct_pkg::window_type       push_win, head_win;
   crct_pkg::queue_status_type q_status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = crct_pkg::reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_step_ff  <= crct_pkg::T_FRAC_BITS'(26214);
         scale_x_ff <= crct_pkg::SCALE_BITS'(65536);
         scale_y_ff <= crct_pkg::SCALE_BITS'(65536);
      end else if (csr_write) begin
         unique case (reg_index)
            crct_pkg::REG_T_STEP:  t_step_ff  <= pwdata[crct_pkg::T_FRAC_BITS-1:0];
            crct_pkg::REG_SCALE_X: scale_x_ff <= pwdata;
            crct_pkg::REG_SCALE_Y: scale_y_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         crct_pkg::REG_T_STEP:  prdata = crct_pkg::CSR_DATA_BITS'(t_step_ff);
         crct_pkg::REG_SCALE_X: prdata = scale_x_ff;
         crct_pkg::REG_SCALE_Y: prdata = scale_y_ff;
         default:               prdata = '0;
      endcase
   end

   assign cfg.t_step  = t_step_ff;
   assign cfg.scale_x = scale_x_ff;
   assign cfg.scale_y = scale_y_ff;

   crct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (q_push),
      .push_win  (push_win)
   );

   crct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_win (push_win),
      .pop      (q_pop),
      .head_win (head_win),
      .status   (q_status)
   );

   crct_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head_win  (head_win),
      .q_status  (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A segment is never pushed into a full queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_status.full)
      else $error("segment pushed into a full queue");

   // The evaluator never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("segment popped from an empty queue");

   // A point that starts a curve only refills the window.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.start_curve) |-> !q_push)
      else $error("curve start produced a segment");

   // A new result comes only from a queued segment.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!q_status.empty))
      else $error("result produced without a queued segment");

endmodule
`default_nettype wire

[tb/sv/catmull_rom_curve_tessellator_tb.sv]
// Self-checking testbench for the Catmull-Rom curve tessellator, with a built-in spline predictor.
module catmull_rom_curve_tessellator_tb;
   import crct_pkg::*;

   localparam longint T_ONE = longint'(1) << T_FRAC_BITS;
   localparam int MAX_RUN = 64;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (COORD_BITS-1)) - 1;
   localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (COORD_BITS-1));

   class spline_sampler_model;
      logic [T_FRAC_BITS-1:0] t_step;
      logic signed [SCALE_BITS-1:0] scale_x;
      logic signed [SCALE_BITS-1:0] scale_y;
      logic signed [COORD_BITS-1:0] win_x [3];
      logic signed [COORD_BITS-1:0] win_y [3];
      int unsigned held;
      longint wt [4];
      sample_type pending [$];
      int unsigned faults;

      function new();
         t_step = 16'd26214;
         scale_x = 32'sd65536;
         scale_y = 32'sd65536;
         for (int i = 0; i < 3; i++) begin
            win_x[i] = '0;
            win_y[i] = '0;
         end
         held = 0;
         faults = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_T_STEP: t_step = value[T_FRAC_BITS-1:0];
            REG_SCALE_X: scale_x = value;
            REG_SCALE_Y: scale_y = value;
            default: ;
         endcase
      endfunction

      // Weighted sum of the four points with the current weights, then scaled and saturated.
      function logic signed [COORD_BITS-1:0] blend_axis(logic signed [COORD_BITS-1:0] p0, p1,
                                                        p2, p3, logic signed [SCALE_BITS-1:0] scale);
         logic signed [127:0] pt [4];
         logic signed [127:0] acc;
         logic signed [127:0] wide_w;
         logic signed [127:0] wide_scale;
         logic signed [127:0] shaped;
         int i;
         pt[0] = p0;
         pt[1] = p1;
         pt[2] = p2;
         pt[3] = p3;
         acc = 0;
         for (i = 0; i < 4; i++) begin
            wide_w = wt[i];
            acc = acc + wide_w * pt[i];
         end
         shaped = (acc + (128'sd1 <<< T_FRAC_BITS)) >>> (T_FRAC_BITS + 1);
         wide_scale = scale;
         shaped = shaped * wide_scale;
         shaped = (shaped + (128'sd1 <<< (SCALE_FRAC - 1))) >>> SCALE_FRAC;
         if (shaped > SAT_HI) return COORD_MAX;
         if (shaped < SAT_LO) return COORD_MIN;
         return shaped[COORD_BITS-1:0];
      endfunction

      function void take_point(point_type p);
         longint t;
         longint t_sq;
         longint t_cu;
         longint stride;
         int n;
         sample_type s;
         if (p.start_curve) held = 0;
         if (held < 3) begin
            win_x[held] = p.point_x;
            win_y[held] = p.point_y;
            held++;
            return;
         end
         stride = (t_step < T_MIN_STEP) ? T_MIN_STEP : t_step;
         t = 0;
         n = 0;
         while (t < T_ONE && n < MAX_RUN) begin
            t_sq = (t * t + T_ONE / 2) >> T_FRAC_BITS;
            t_cu = (t_sq * t + T_ONE / 2) >> T_FRAC_BITS;
            wt[0] = -t_cu + 2 * t_sq - t;
            wt[1] = 3 * t_cu - 5 * t_sq + 2 * T_ONE;
            wt[2] = -3 * t_cu + 4 * t_sq + t;
            wt[3] = t_cu - t_sq;
            s.sample_x = blend_axis(win_x[0], win_x[1], win_x[2], p.point_x, scale_x);
            s.sample_y = blend_axis(win_y[0], win_y[1], win_y[2], p.point_y, scale_y);
            s.last_sample = (t + stride >= T_ONE);
            pending.insert(pending.size(), s);
            n++;
            t = t + stride;
         end
         win_x[0] = win_x[1];
         win_y[0] = win_y[1];
         win_x[1] = win_x[2];
         win_y[1] = win_y[2];
         win_x[2] = p.point_x;
         win_y[2] = p.point_y;
      endfunction

      function void compare_sample(sample_type got);
         sample_type want;
         if (pending.size() == 0) begin
            $error("unexpected sample: x %0d, y %0d", got.sample_x, got.sample_y);
            faults++;
            return;
         end
         want = pending.pop_front();
         if (got.sample_x !== want.sample_x) begin
            $error("sample_x: expected %0d, got %0d", want.sample_x, got.sample_x);
            faults++;
         end
         if (got.sample_y !== want.sample_y) begin
            $error("sample_y: expected %0d, got %0d", want.sample_y, got.sample_y);
            faults++;
         end
         if (got.last_sample !== want.last_sample) begin
            $error("last_sample: expected %0b, got %0b", want.last_sample, got.last_sample);
            faults++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   point_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   sample_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   spline_sampler_model sampler;
   bit steady = 1'b0;

   catmull_rom_curve_tessellator uut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .psel,
      .penable,
      .pwrite,
      .paddr,
      .pwdata,
      .prdata,
      .pready
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sampler.compare_sample(rsp_data);
      rsp_stall <= !steady && ($urandom_range(99) < 34);
   end

   function automatic logic [COORD_BITS-1:0] random_coord();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) return COORD_BITS'($urandom_range(2097151)) - COORD_BITS'(1048576);
      if (pick < 60) begin
         case ($urandom_range(3))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return $urandom();
   endfunction

   task automatic send_point(point_type p);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sampler.take_point(p);
   endtask

   // Writes end with an idle wait after psel drops, so that psel never toggles twice in one step.
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(4 * idx);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sampler.set_reg(idx, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sampler.pending.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic run_phase(int count, logic [31:0] step_word, logic [31:0] sx,
                            logic [31:0] sy, bit calm);
      point_type p;
      drain();
      write_reg(REG_T_STEP, step_word);
      write_reg(REG_SCALE_X, sx);
      write_reg(REG_SCALE_Y, sy);
      steady = calm;
      for (int k = 0; k < count; k++) begin
         p.point_x = random_coord();
         p.point_y = random_coord();
         p.start_curve = (k == 0) || ($urandom_range(99) < 8);
         send_point(p);
      end
      req_valid <= 1'b0;
      steady = 1'b0;
   endtask

   initial begin
      sampler = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Opening curve at the reset settings, with extreme coordinates that overshoot.
      send_point(point_type'{32'h0000_0000, 32'h0000_0000, 1'b1});
      send_point(point_type'{32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
      send_point(point_type'{32'h8000_0000, 32'h7FFF_FFFF, 1'b0});
      send_point(point_type'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0});
      send_point(point_type'{32'h8000_0000, 32'h8000_0000, 1'b0});
      send_point(point_type'{32'hFFFF_FFFF, 32'h0000_0001, 1'b0});
      send_point(point_type'{32'h0000_0001, 32'hFFFF_FFFF, 1'b0});
      // A new curve restarted again while its window is still filling.
      send_point(point_type'{32'h0001_0000, 32'hFFFF_0000, 1'b1});
      send_point(point_type'{32'h1234_5678, 32'h8765_4321, 1'b1});
      send_point(point_type'{32'h0003_0000, 32'h0002_8000, 1'b0});
      send_point(point_type'{32'hFFFC_0000, 32'h0001_4000, 1'b0});
      send_point(point_type'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0});
      send_point(point_type'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0});
      send_point(point_type'{32'h0000_8000, 32'hFFFF_8000, 1'b0});
      send_point(point_type'{32'h7FFF_0000, 32'h8001_0000, 1'b1});
      send_point(point_type'{32'h0000_0000, 32'h0000_0000, 1'b0});
      req_valid <= 1'b0;

      run_phase(60, 32'd16384, 32'sd65536, 32'sd65536, 1'b0);
      run_phase(50, 32'd65535, COORD_MAX, COORD_MIN, 1'b0);
      run_phase(20, 32'd1024, -32'sd65536, 32'sd131072, 1'b0);
      // A write past the last register must leave the settings alone.
      drain();
      write_reg(REG_UNUSED, 32'h0000_0400);
      run_phase(15, 32'd0, $urandom(), $urandom(), 1'b0);
      run_phase(15, 32'd500, $urandom(), $urandom(), 1'b0);
      // Upper bits of the step word are not part of the register.
      run_phase(80, 32'hABCD_6666, $urandom(), $urandom(), 1'b1);
      run_phase(60, $urandom_range(65535, 1024),
                32'($urandom_range(262143)) - 32'd131072,
                32'($urandom_range(262143)) - 32'd131072, 1'b0);
      run_phase(50, 32'd13107, 32'sd1, -32'sd1, 1'b0);

      drain();
      if (sampler.faults == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[files.f]
src/crct_pkg.sv
src/crct_front.sv
src/crct_queue.sv
src/crct_eval.sv
src/catmull_rom_curve_tessellator.sv
tb/sv/catmull_rom_curve_tessellator_tb.sv
